/* src/r2fft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and twiddle ROM builder for the radix-2 FFT engine.
package r2fft_pkg;

    localparam int DEF_MAX_LOG2_SIZE = 10;
    localparam int DEF_ACC_WIDTH     = 32;
    localparam int DEF_TWIDDLE_WIDTH = 16;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int BIN_WIDTH      = 32;
    localparam int LOG2_REG_WIDTH = 4;
    localparam int THR_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH = 2;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LOG2_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_INVERSE_MODE = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_IMAG_SNAP    = 2'd2;

    localparam logic [LOG2_REG_WIDTH-1:0] LOG2_SIZE_RESET = 4'd10;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] sample_real;
        logic signed [SAMPLE_WIDTH-1:0] sample_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [BIN_WIDTH-1:0] bin_real;
        logic signed [BIN_WIDTH-1:0] bin_imag;
        logic                        bin_valid;
        logic                        last_bin;
    } t_out_item;

    // butterfly datapath step, one per cycle of the multiply sequence
    typedef enum logic [2:0] {
        BF_HOLD  = 3'd0,
        BF_CAP_X = 3'd1,
        BF_M0    = 3'd2,
        BF_M1    = 3'd3,
        BF_M2    = 3'd4,
        BF_M3    = 3'd5,
        BF_M4    = 3'd6,
        BF_M5    = 3'd7
    } t_bf_op;

    function automatic longint unsigned isqrt64(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        longint unsigned v;
        int it;
        r = 0;
        b = 64'd1 << 62;
        v = x;
        for (it = 0; it < 32; it++) begin
            if (b > v) b = b >> 2;
        end
        for (it = 0; it < 32; it++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // restoring long division, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        int i;
        q   = 0;
        rem = 0;
        for (i = 63; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // cos or sin of 2*pi*k/2^max_l2 in Q1.(tw-1), built by half-angle steps in Q2.30
    function automatic longint rom_entry(input int k, input int max_l2, input int tw,
                                         input bit want_sin);
        longint bc [16];
        longint bs [16];
        longint c;
        longint s;
        longint nc;
        longint ns;
        longint q30;
        longint hi;
        longint lo;
        longint unsigned uc;
        longint unsigned us;
        longint unsigned ut;
        int nb;
        int sh;
        int j;
        q30 = longint'(1) << 30;
        nb  = max_l2 - 1;
        sh  = 31 - tw;
        for (j = 0; j < 16; j++) begin
            bc[j] = 0;
            bs[j] = 0;
        end
        if (nb > 0) begin
            bc[nb-1] = 0;
            bs[nb-1] = q30;
            for (j = nb - 1; j > 0; j--) begin
                ut = q30 + bc[j];
                uc = isqrt64(ut << 29);
                ut = bs[j];
                us = udiv64((ut << 30) + uc, uc << 1);
                bc[j-1] = uc;
                bs[j-1] = us;
            end
        end
        c = q30;
        s = 0;
        for (j = 0; j < nb; j++) begin
            if (((k >> j) & 1) != 0) begin
                nc = (c * bc[j] - s * bs[j] + (longint'(1) << 29)) >>> 30;
                ns = (c * bs[j] + s * bc[j] + (longint'(1) << 29)) >>> 30;
                c  = nc;
                s  = ns;
            end
        end
        if (want_sin) c = s;
        c  = (c + (longint'(1) << (sh - 1))) >>> sh;
        hi = (longint'(1) << (tw - 1)) - 1;
        lo = -hi - 1;
        if (c > hi) c = hi;
        else if (c < lo) c = lo;
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/r2fft_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sample store: one write port, one registered read port.
module r2fft_store #(
    parameter int ADDR_WIDTH = 10,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [ADDR_WIDTH-1:0] i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [ADDR_WIDTH-1:0] i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);
    logic [DATA_WIDTH-1:0] mem [1 << ADDR_WIDTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* src/r2fft_twiddle.sv */
`timescale 1ns / 1ps
`default_nettype none
// Twiddle ROM with registered lookup and conjugation for the inverse transform.
module r2fft_twiddle #(
    parameter int MAX_LOG2_SIZE = 10,
    parameter int TWIDDLE_WIDTH = 16,
    parameter int ROM_AW        = 9
) (
    input  wire logic                       i_clk,
    input  wire logic [ROM_AW-1:0]          i_idx,
    input  wire logic                       i_inverse,
    output logic signed [TWIDDLE_WIDTH:0]   o_wc,
    output logic signed [TWIDDLE_WIDTH:0]   o_ws
);
    import r2fft_pkg::*;

    localparam int RomDepth = 1 << (MAX_LOG2_SIZE - 1);

    logic signed [TWIDDLE_WIDTH-1:0] w_cos [RomDepth];
    logic signed [TWIDDLE_WIDTH-1:0] w_sin [RomDepth];
    logic signed [TWIDDLE_WIDTH:0]   w_sin_x;
    logic signed [TWIDDLE_WIDTH:0]   r_wc;
    logic signed [TWIDDLE_WIDTH:0]   r_ws;

    for (genvar k = 0; k < RomDepth; k++) begin : g_rom
        localparam longint CosV = rom_entry(k, MAX_LOG2_SIZE, TWIDDLE_WIDTH, 1'b0);
        localparam longint SinV = rom_entry(k, MAX_LOG2_SIZE, TWIDDLE_WIDTH, 1'b1);
        assign w_cos[k] = CosV[TWIDDLE_WIDTH-1:0];
        assign w_sin[k] = SinV[TWIDDLE_WIDTH-1:0];
    end

    assign w_sin_x = {w_sin[i_idx][TWIDDLE_WIDTH-1], w_sin[i_idx]};

    always_ff @(posedge i_clk) begin
        r_wc <= {w_cos[i_idx][TWIDDLE_WIDTH-1], w_cos[i_idx]};
        r_ws <= i_inverse ? -w_sin_x : w_sin_x;
    end

    assign o_wc = r_wc;
    assign o_ws = r_ws;
endmodule
`default_nettype wire

/* src/r2fft_bfly.sv */
`timescale 1ns / 1ps
`default_nettype none
// Butterfly datapath: one shared multiplier, accumulate, round, add/subtract.
module r2fft_bfly #(
    parameter int ACC_WIDTH     = 32,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire r2fft_pkg::t_bf_op              i_op,
    input  wire logic signed [ACC_WIDTH-1:0]    i_rd_re,
    input  wire logic signed [ACC_WIDTH-1:0]    i_rd_im,
    input  wire logic signed [TWIDDLE_WIDTH:0]  i_wc,
    input  wire logic signed [TWIDDLE_WIDTH:0]  i_ws,
    output logic signed [ACC_WIDTH-1:0]         o_p_re,
    output logic signed [ACC_WIDTH-1:0]         o_p_im,
    output logic signed [ACC_WIDTH-1:0]         o_q_re,
    output logic signed [ACC_WIDTH-1:0]         o_q_im
);
    import r2fft_pkg::*;

    localparam int PW  = ACC_WIDTH + TWIDDLE_WIDTH + 1;
    localparam int TDW = ACC_WIDTH + 3;
    localparam int SW  = TDW + 1;
    localparam logic signed [PW:0]   RndBias = (PW+1)'(1) << (TWIDDLE_WIDTH - 2);
    localparam logic signed [SW-1:0] AccMax  =
        SW'((longint'(1) << (ACC_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] AccMin  = -AccMax - SW'(1);

    logic signed [ACC_WIDTH-1:0]     r_xr, r_xi, r_ur, r_ui;
    logic signed [PW-1:0]            r_prod;
    logic signed [PW:0]              r_acc_r, r_acc_i;
    logic signed [TDW-1:0]           r_tr, r_ti;
    logic signed [ACC_WIDTH-1:0]     w_mul_a;
    logic signed [TWIDDLE_WIDTH:0]   w_mul_b;
    logic signed [PW-1:0]            w_prod;
    logic signed [PW:0]              w_prod_x;
    logic signed [PW:0]              w_sh_r, w_sh_i;

    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
        if (v > AccMax) return AccMax[ACC_WIDTH-1:0];
        if (v < AccMin) return AccMin[ACC_WIDTH-1:0];
        return v[ACC_WIDTH-1:0];
    endfunction

    // xr*wc, xi*ws, xi*wc, xr*ws over steps M0..M3
    assign w_mul_a  = (i_op == BF_M0 || i_op == BF_M3) ? r_xr : r_xi;
    assign w_mul_b  = (i_op == BF_M0 || i_op == BF_M2) ? i_wc : i_ws;
    assign w_prod   = w_mul_a * w_mul_b;
    assign w_prod_x = {r_prod[PW-1], r_prod};
    assign w_sh_r   = (r_acc_r + RndBias) >>> (TWIDDLE_WIDTH - 1);
    assign w_sh_i   = (r_acc_i + RndBias) >>> (TWIDDLE_WIDTH - 1);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            BF_CAP_X: begin
                r_xr <= i_rd_re;
                r_xi <= i_rd_im;
            end
            BF_M0: begin
                r_ur   <= i_rd_re;
                r_ui   <= i_rd_im;
                r_prod <= w_prod;
            end
            BF_M1: begin
                r_acc_r <= w_prod_x;
                r_prod  <= w_prod;
            end
            BF_M2: begin
                r_acc_r <= r_acc_r - w_prod_x;
                r_prod  <= w_prod;
            end
            BF_M3: begin
                r_acc_i <= w_prod_x;
                r_prod  <= w_prod;
            end
            BF_M4: begin
                r_acc_i <= r_acc_i + w_prod_x;
                r_tr    <= w_sh_r[TDW-1:0];
            end
            BF_M5: begin
                r_ti <= w_sh_i[TDW-1:0];
            end
            BF_HOLD: ;
            default: ;
        endcase
    end

    assign o_p_re = sat_acc(SW'(r_ur) + SW'(r_tr));
    assign o_p_im = sat_acc(SW'(r_ui) + SW'(r_ti));
    assign o_q_re = sat_acc(SW'(r_ur) - SW'(r_tr));
    assign o_q_im = sat_acc(SW'(r_ui) - SW'(r_ti));
endmodule
`default_nettype wire

/* src/radix2_fft_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 FFT engine top level: load/read sequencer and transform control.
//
// Load words write complex samples in order into a single-port-read store of
// 2^MAX_LOG2_SIZE entries; the load that fills the frame starts an in-place
// decimation-in-time transform and the block takes no word until it ends.
// The transform is bound by the store's one read and one write port and the
// one shared multiplier: the bit-reversal pass checks every entry and swaps
// each reversed pair with two reads and two writes, each butterfly runs two
// reads, four multiply steps, two roundings and two writes, and inverse mode
// adds a read, a snap-and-scale step and a write per entry. Read words return
// bins in order, saturated to 32 bits; a read before any transform, or after a
// new frame began loading, returns a zero word with bin_valid low.
// Configuration is written through a plain write port and must be changed
// only while the block is idle. No clearing pass.
module radix2_fft_engine #(
    parameter int MAX_LOG2_SIZE = r2fft_pkg::DEF_MAX_LOG2_SIZE,
    parameter int ACC_WIDTH     = r2fft_pkg::DEF_ACC_WIDTH,
    parameter int TWIDDLE_WIDTH = r2fft_pkg::DEF_TWIDDLE_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire r2fft_pkg::t_in_item                   i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output r2fft_pkg::t_out_item                       o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [r2fft_pkg::CFG_ADDR_WIDTH-1:0]  i_cfg_addr,
    input  wire logic [r2fft_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import r2fft_pkg::*;

    localparam int Aw     = MAX_LOG2_SIZE;
    localparam int Nw     = MAX_LOG2_SIZE + 1;
    localparam int LW     = $clog2(MAX_LOG2_SIZE + 1);
    localparam int RomAw  = (MAX_LOG2_SIZE > 1) ? MAX_LOG2_SIZE - 1 : 1;
    localparam int EntW   = 2 * ACC_WIDTH;
    localparam int XW     = (ACC_WIDTH > BIN_WIDTH) ? ACC_WIDTH : BIN_WIDTH;
    localparam logic signed [XW-1:0] BinMax =
        XW'((longint'(1) << (BIN_WIDTH - 1)) - 1);
    localparam logic signed [XW-1:0] BinMin = -BinMax - XW'(1);

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_RDOUT   = 20'h00002,
        ST_BR_CHK  = 20'h00004,
        ST_BR_RDI  = 20'h00008,
        ST_BR_RDR  = 20'h00010,
        ST_BR_WI   = 20'h00020,
        ST_BR_WR   = 20'h00040,
        ST_BF_RDQ  = 20'h00080,
        ST_BF_RDP  = 20'h00100,
        ST_BF_M0   = 20'h00200,
        ST_BF_M1   = 20'h00400,
        ST_BF_M2   = 20'h00800,
        ST_BF_M3   = 20'h01000,
        ST_BF_M4   = 20'h02000,
        ST_BF_M5   = 20'h04000,
        ST_BF_WP   = 20'h08000,
        ST_BF_WQ   = 20'h10000,
        ST_IV_RD   = 20'h20000,
        ST_IV_CALC = 20'h40000,
        ST_IV_WR   = 20'h80000
    } t_state;

    // control state
    t_state                    r_state, n_state;
    logic [LOG2_REG_WIDTH-1:0] r_log2;
    logic                      r_inv;
    logic [THR_WIDTH-1:0]      r_thr;
    logic [Aw-1:0]             r_load_cnt, n_load_cnt;
    logic [Aw-1:0]             r_read_cnt, n_read_cnt;
    logic                      r_done, n_done;
    logic                      r_out_valid, n_out_valid;

    // transform loop registers and output word
    logic [Aw-1:0]             r_i, n_i;
    logic [Aw-1:0]             r_j, n_j;
    logic [Aw-1:0]             r_b, n_b;
    logic [Aw-1:0]             r_half, n_half;
    logic [LW-1:0]             r_tsh, n_tsh;
    logic [LW-1:0]             r_l, n_l;
    logic [Nw-1:0]             r_n, n_n;
    logic                      r_inv_x, n_inv_x;
    logic [EntW-1:0]           r_hold, n_hold;
    logic                      r_last, n_last;
    t_out_item                 r_out, n_out;

    // store, twiddle and butterfly hookup
    logic                      w_we;
    logic [Aw-1:0]             w_waddr;
    logic [EntW-1:0]           w_wdata;
    logic [Aw-1:0]             w_raddr;
    logic [EntW-1:0]           w_rdata;
    logic [RomAw-1:0]          w_ti;
    logic signed [TWIDDLE_WIDTH:0] w_wc, w_ws;
    t_bf_op                    w_bf_op;
    logic signed [ACC_WIDTH-1:0] w_p_re, w_p_im, w_q_re, w_q_im;
    logic signed [ACC_WIDTH-1:0] w_rd_re, w_rd_im;

    // derived control values
    logic [LW-1:0]             w_l_cur;
    logic [Nw-1:0]             w_n;
    logic                      w_in_ready, w_in_acc;
    logic                      w_load_last;
    logic [Aw-1:0]             w_rc_eff, w_rc_next;
    logic                      w_rc_last;
    logic [Aw-1:0]             w_nm1;
    logic [Aw-1:0]             w_hmask, w_p, w_q;
    logic [Aw-1:0]             w_rev_full, w_rev;
    logic                      w_stage_end, w_all_end;
    logic signed [ACC_WIDTH:0] w_mag;
    logic signed [ACC_WIDTH:0] w_half, w_sc_re, w_sc_im;
    logic signed [ACC_WIDTH-1:0] w_im_snap;

    function automatic logic signed [BIN_WIDTH-1:0] sat_bin(
        input logic signed [ACC_WIDTH-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > BinMax) return BinMax[BIN_WIDTH-1:0];
        if (x < BinMin) return BinMin[BIN_WIDTH-1:0];
        return x[BIN_WIDTH-1:0];
    endfunction

    r2fft_store #(
        .ADDR_WIDTH (Aw),
        .DATA_WIDTH (EntW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    r2fft_twiddle #(
        .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH),
        .ROM_AW        (RomAw)
    ) u_twiddle (
        .i_clk     (i_clk),
        .i_idx     (w_ti),
        .i_inverse (r_inv_x),
        .o_wc      (w_wc),
        .o_ws      (w_ws)
    );

    r2fft_bfly #(
        .ACC_WIDTH     (ACC_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_bfly (
        .i_clk   (i_clk),
        .i_op    (w_bf_op),
        .i_rd_re (w_rd_re),
        .i_rd_im (w_rd_im),
        .i_wc    (w_wc),
        .i_ws    (w_ws),
        .o_p_re  (w_p_re),
        .o_p_im  (w_p_im),
        .o_q_re  (w_q_re),
        .o_q_im  (w_q_im)
    );

    assign w_rd_re = w_rdata[EntW-1:ACC_WIDTH];
    assign w_rd_im = w_rdata[ACC_WIDTH-1:0];

    // clamp log2_size into the supported range
    always_comb begin
        if (r_log2 == '0) w_l_cur = LW'(1);
        else if (int'(r_log2) > MAX_LOG2_SIZE) w_l_cur = LW'(MAX_LOG2_SIZE);
        else w_l_cur = LW'(r_log2);
    end
    assign w_n = Nw'(1) << w_l_cur;

    assign w_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc    = i_in_valid && w_in_ready;
    assign w_load_last = {1'b0, r_load_cnt} >= (w_n - Nw'(1));

    // read pointer restarts when the length shrank under it
    assign w_rc_eff  = ({1'b0, r_read_cnt} >= w_n) ? '0 : r_read_cnt;
    assign w_rc_last = ({1'b0, w_rc_eff} == (w_n - Nw'(1)));
    assign w_rc_next = w_rc_last ? '0 : w_rc_eff + Aw'(1);

    // butterfly addressing: p = b with a zero inserted at the stage bit
    assign w_nm1       = Aw'(r_n - Nw'(1));
    assign w_hmask     = r_half - Aw'(1);
    assign w_p         = r_b + (r_b & ~w_hmask);
    assign w_q         = w_p + r_half;
    assign w_ti        = RomAw'((r_b & w_hmask) << r_tsh);
    assign w_stage_end = ({1'b0, r_b} == ((r_n >> 1) - Nw'(1)));
    assign w_all_end   = ({r_half, 1'b0} == r_n);

    always_comb begin
        for (int k = 0; k < Aw; k++) w_rev_full[k] = r_i[Aw-1-k];
    end
    assign w_rev = w_rev_full >> (LW'(MAX_LOG2_SIZE) - r_l);

    // inverse pass: snap small imaginary parts, then rounded divide by n
    assign w_mag     = w_rd_im[ACC_WIDTH-1] ? -(ACC_WIDTH+1)'(w_rd_im)
                                            : (ACC_WIDTH+1)'(w_rd_im);
    assign w_im_snap = ($unsigned(w_mag) < (ACC_WIDTH+1)'(r_thr)) ? '0 : w_rd_im;
    assign w_half    = (ACC_WIDTH+1)'(1) << (r_l - LW'(1));
    assign w_sc_re   = ((ACC_WIDTH+1)'(w_rd_re) + w_half) >>> r_l;
    assign w_sc_im   = ((ACC_WIDTH+1)'(w_im_snap) + w_half) >>> r_l;

    always_comb begin
        unique case (r_state)
            ST_BF_RDP: w_bf_op = BF_CAP_X;
            ST_BF_M0:  w_bf_op = BF_M0;
            ST_BF_M1:  w_bf_op = BF_M1;
            ST_BF_M2:  w_bf_op = BF_M2;
            ST_BF_M3:  w_bf_op = BF_M3;
            ST_BF_M4:  w_bf_op = BF_M4;
            ST_BF_M5:  w_bf_op = BF_M5;
            default:   w_bf_op = BF_HOLD;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_read_cnt  = r_read_cnt;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_out_ready;
        n_i         = r_i;
        n_j         = r_j;
        n_b         = r_b;
        n_half      = r_half;
        n_tsh       = r_tsh;
        n_l         = r_l;
        n_n         = r_n;
        n_inv_x     = r_inv_x;
        n_hold      = r_hold;
        n_last      = r_last;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.func == FUNC_LOAD) begin
                        w_we    = 1'b1;
                        w_waddr = r_load_cnt;
                        w_wdata = {ACC_WIDTH'(i_in_data.sample_real),
                                   ACC_WIDTH'(i_in_data.sample_imag)};
                        n_done  = 1'b0;
                        if (w_load_last) begin
                            // frame full: latch the setup and start the transform
                            n_load_cnt = '0;
                            n_read_cnt = '0;
                            n_l        = w_l_cur;
                            n_n        = w_n;
                            n_inv_x    = r_inv;
                            n_i        = '0;
                            n_state    = ST_BR_CHK;
                        end else begin
                            n_load_cnt = r_load_cnt + Aw'(1);
                        end
                    end else if (!r_done) begin
                        n_out       = '0;
                        n_out_valid = 1'b1;
                    end else begin
                        w_raddr    = w_rc_eff;
                        n_last     = w_rc_last;
                        n_read_cnt = w_rc_next;
                        n_state    = ST_RDOUT;
                    end
                end
            end
            ST_RDOUT: begin
                n_out.bin_real  = sat_bin(w_rd_re);
                n_out.bin_imag  = sat_bin(w_rd_im);
                n_out.bin_valid = 1'b1;
                n_out.last_bin  = r_last;
                n_out_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_BR_CHK, ST_BR_WR: begin
                if (r_state == ST_BR_WR) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_hold;
                end
                if (r_state == ST_BR_CHK && r_i < w_rev) begin
                    n_j     = w_rev;
                    n_state = ST_BR_RDI;
                end else if (r_i == w_nm1) begin
                    n_b     = '0;
                    n_half  = Aw'(1);
                    n_tsh   = LW'(MAX_LOG2_SIZE - 1);
                    n_state = ST_BF_RDQ;
                end else begin
                    n_i     = r_i + Aw'(1);
                    n_state = ST_BR_CHK;
                end
            end
            ST_BR_RDI: begin
                w_raddr = r_i;
                n_state = ST_BR_RDR;
            end
            ST_BR_RDR: begin
                w_raddr = r_j;
                n_hold  = w_rdata;
                n_state = ST_BR_WI;
            end
            ST_BR_WI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
                n_state = ST_BR_WR;
            end
            ST_BF_RDQ: begin
                w_raddr = w_q;
                n_state = ST_BF_RDP;
            end
            ST_BF_RDP: begin
                w_raddr = w_p;
                n_state = ST_BF_M0;
            end
            ST_BF_M0: n_state = ST_BF_M1;
            ST_BF_M1: n_state = ST_BF_M2;
            ST_BF_M2: n_state = ST_BF_M3;
            ST_BF_M3: n_state = ST_BF_M4;
            ST_BF_M4: n_state = ST_BF_M5;
            ST_BF_M5: n_state = ST_BF_WP;
            ST_BF_WP: begin
                w_we    = 1'b1;
                w_waddr = w_p;
                w_wdata = {w_p_re, w_p_im};
                n_state = ST_BF_WQ;
            end
            ST_BF_WQ: begin
                w_we    = 1'b1;
                w_waddr = w_q;
                w_wdata = {w_q_re, w_q_im};
                if (!w_stage_end) begin
                    n_b     = r_b + Aw'(1);
                    n_state = ST_BF_RDQ;
                end else if (!w_all_end) begin
                    n_b     = '0;
                    n_half  = r_half << 1;
                    n_tsh   = r_tsh - LW'(1);
                    n_state = ST_BF_RDQ;
                end else if (r_inv_x) begin
                    n_i     = '0;
                    n_state = ST_IV_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_IV_RD: begin
                w_raddr = r_i;
                n_state = ST_IV_CALC;
            end
            ST_IV_CALC: begin
                n_hold  = {w_sc_re[ACC_WIDTH-1:0], w_sc_im[ACC_WIDTH-1:0]};
                n_state = ST_IV_WR;
            end
            ST_IV_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_hold;
                if (r_i == w_nm1) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + Aw'(1);
                    n_state = ST_IV_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_log2      <= LOG2_SIZE_RESET;
            r_inv       <= 1'b0;
            r_thr       <= '0;
            r_load_cnt  <= '0;
            r_read_cnt  <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_read_cnt  <= n_read_cnt;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_LOG2_SIZE:    r_log2 <= i_cfg_data[LOG2_REG_WIDTH-1:0];
                    CFG_INVERSE_MODE: r_inv  <= i_cfg_data[0];
                    CFG_IMAG_SNAP:    r_thr  <= i_cfg_data[THR_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_b     <= n_b;
        r_half  <= n_half;
        r_tsh   <= n_tsh;
        r_l     <= n_l;
        r_n     <= n_n;
        r_inv_x <= n_inv_x;
        r_hold  <= n_hold;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a read of a finished transform goes through the store read cycle
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.func == FUNC_READ && r_done) |=> (r_state == ST_RDOUT))
        else $error("read word did not enter the store read cycle");

    // the output register is free when a bin comes back from the store
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDOUT) |-> !r_out_valid)
        else $error("output word overwritten before it was taken");

    // butterfly partner stays inside the frame
    a_bf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BF_RDQ) |-> ({1'b0, w_q} < r_n && {r_half, 1'b0} <= r_n))
        else $error("butterfly address outside the frame");

    // each bit-reversal swap is done once, from the lower index
    a_br_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BR_RDI) |-> (r_i < r_j && $past(r_state) == ST_BR_CHK))
        else $error("bit-reversal swap out of order");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the radix-2 FFT engine: random frames against a bit-true predictor.
module tb_top;
    import r2fft_pkg::*;

    localparam int     MAXL        = 10;
    localparam int     DEPTH       = 1 << MAXL;
    localparam int     ROMN        = 1 << (MAXL - 1);
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     RANDOM_WORDS = 640;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      o_in_ready;
    t_in_item                  in_data = '0;
    logic                      o_out_valid;
    logic                      out_ready = 1'b0;
    t_out_item                 o_out_data;
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = CFG_LOG2_SIZE;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    always #1 i_clk = ~i_clk;

    radix2_fft_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: twiddle tables, sample store, counters, registers
    // ---------------------------------------------------------------
    longint    tw_cos [ROMN];
    longint    tw_sin [ROMN];
    longint    re_st  [DEPTH];
    longint    im_st  [DEPTH];
    int        ld_cnt;
    int        rd_cnt;
    bit        xf_done;
    int        cfg_l2;
    int        cfg_inv;
    int        cfg_thr;

    t_out_item bins_due [$];       // expected bins, oldest first
    t_in_item  words_pending [$];  // words waiting for the driver
    int        err_cnt = 0;
    longint    cyc = 0;
    bit        burst_mode = 1'b0;  // no idling on either side while set
    int        total_words = 0;

    // Generator-side view of the frame, used to keep reads inside written entries and to size frames
    int        g_cnt;
    int        g_top;
    int        g_n;
    bit        g_done;

    function automatic int clamp_l2(input int v);
        if (v < 1) return 1;
        if (v > MAXL) return MAXL;
        return v;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Build cos/sin of 2*pi*k/DEPTH: half-angle steps in Q2.30, then round to Q1.15
    task automatic build_twiddles();
        longint          bc [MAXL];
        longint          bs [MAXL];
        longint          c;
        longint          s;
        longint          nc;
        longint          ns;
        longint          q30;
        longint unsigned uc;
        int              j;
        int              k;
        q30 = longint'(1) << 30;
        bc[MAXL-2] = 0;
        bs[MAXL-2] = q30;
        for (j = MAXL - 2; j > 0; j--) begin
            uc = root_floor(longint'(q30 + bc[j]) << 29);
            bc[j-1] = uc;
            bs[j-1] = ((longint'(bs[j]) << 30) + uc) / (2 * uc);
        end
        for (k = 0; k < ROMN; k++) begin
            c = q30;
            s = 0;
            for (j = 0; j < MAXL - 1; j++) begin
                if (((k >> j) & 1) != 0) begin
                    nc = (c * bc[j] - s * bs[j] + (longint'(1) << 29)) >>> 30;
                    ns = (c * bs[j] + s * bc[j] + (longint'(1) << 29)) >>> 30;
                    c  = nc;
                    s  = ns;
                end
            end
            c = (c + (longint'(1) << 14)) >>> 15;
            s = (s + (longint'(1) << 14)) >>> 15;
            tw_cos[k] = (c > 32767) ? 32767 : ((c < -32768) ? -32768 : c);
            tw_sin[k] = (s > 32767) ? 32767 : ((s < -32768) ? -32768 : s);
        end
    endtask

    // In-place DIT transform over entries 0..2^l-1 of the store
    task automatic run_fft(input int l);
        int     n;
        int     i;
        int     r;
        int     b;
        int     st;
        int     m;
        int     k;
        int     j;
        int     ti;
        int     p;
        int     q;
        longint t;
        longint wc;
        longint ws;
        longint tr;
        longint tim;
        longint ur;
        longint ui;
        longint half;
        longint im;
        n = 1 << l;
        // bit-reversed reorder
        for (i = 0; i < n; i++) begin
            r = 0;
            for (b = 0; b < l; b++) r |= ((i >> b) & 1) << (l - 1 - b);
            if (i < r) begin
                t = re_st[i]; re_st[i] = re_st[r]; re_st[r] = t;
                t = im_st[i]; im_st[i] = im_st[r]; im_st[r] = t;
            end
        end
        for (st = 1; st <= l; st++) begin
            m = 1 << st;
            for (k = 0; k < n; k += m) begin
                for (j = 0; j < m / 2; j++) begin
                    ti  = (j << (MAXL - st)) & (ROMN - 1);
                    wc  = tw_cos[ti];
                    ws  = cfg_inv ? -tw_sin[ti] : tw_sin[ti];
                    p   = k + j;
                    q   = k + j + m / 2;
                    // products stay well inside 64 bits, so round half up directly
                    tr  = (re_st[q] * wc - im_st[q] * ws + 16384) >>> 15;
                    tim = (im_st[q] * wc + re_st[q] * ws + 16384) >>> 15;
                    ur  = re_st[p];
                    ui  = im_st[p];
                    re_st[p] = sat32(ur + tr);
                    im_st[p] = sat32(ui + tim);
                    re_st[q] = sat32(ur - tr);
                    im_st[q] = sat32(ui - tim);
                end
            end
        end
        if (cfg_inv) begin
            half = longint'(1) << (l - 1);
            for (i = 0; i < n; i++) begin
                im = im_st[i];
                // snap small imaginary parts, then scale by 1/n with rounding
                if (((im < 0) ? -im : im) < cfg_thr) im = 0;
                re_st[i] = (re_st[i] + half) >>> l;
                im_st[i] = (im + half) >>> l;
            end
        end
    endtask

    // Advance the predicted engine by one accepted word; queue the bin a read returns
    task automatic advance_engine(input t_in_item w);
        int        l;
        int        n;
        int        a;
        t_out_item o;
        l = clamp_l2(cfg_l2);
        n = 1 << l;
        if (w.func == FUNC_LOAD) begin
            a = ld_cnt & (DEPTH - 1);
            xf_done = 1'b0;
            re_st[a] = longint'(w.sample_real);
            im_st[a] = longint'(w.sample_imag);
            if (ld_cnt >= n - 1) begin
                run_fft(l);
                ld_cnt  = 0;
                rd_cnt  = 0;
                xf_done = 1'b1;
            end else begin
                ld_cnt = (ld_cnt + 1) & 2047;
            end
        end else begin
            o = '0;
            if (xf_done) begin
                if (rd_cnt >= n) rd_cnt = 0;
                o.bin_real  = BIN_WIDTH'(sat32(re_st[rd_cnt & (DEPTH - 1)]));
                o.bin_imag  = BIN_WIDTH'(sat32(im_st[rd_cnt & (DEPTH - 1)]));
                o.bin_valid = 1'b1;
                o.last_bin  = (rd_cnt == n - 1);
                rd_cnt = (rd_cnt + 1 >= n) ? 0 : rd_cnt + 1;
            end
            bins_due.push_back(o);
        end
    endtask

    // Mostly short gaps, a few long ones; none while in burst mode
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic push_load(input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im);
        t_in_item w;
        w.func        = FUNC_LOAD;
        w.sample_real = re;
        w.sample_imag = im;
        words_pending.push_back(w);
        total_words++;
        if ((g_cnt & (DEPTH - 1)) + 1 > g_top) g_top = (g_cnt & (DEPTH - 1)) + 1;
        g_done = 1'b0;
        if (g_cnt >= g_n - 1) begin
            g_cnt  = 0;
            g_done = 1'b1;
        end else begin
            g_cnt = (g_cnt + 1) & 2047;
        end
    endtask

    // Drop a read that would reach an entry never written since reset
    task automatic push_read();
        t_in_item w;
        if (g_done && g_n > g_top) return;
        w.func        = FUNC_READ;
        w.sample_real = rand_sample();
        w.sample_imag = rand_sample();
        words_pending.push_back(w);
        total_words++;
    endtask

    // Hold until everything has drained and the engine has had time to finish a transform
    task automatic wait_idle();
        int l;
        do @(posedge i_clk);
        while (words_pending.size() != 0 || in_valid || bins_due.size() != 0);
        l = clamp_l2(cfg_l2);
        repeat ((5 * l + 9) * (1 << l) + 100) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_WIDTH-1:0] idx, input int val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DATA_WIDTH'(val);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_LOG2_SIZE: begin
                cfg_l2 = val & 15;
                g_n    = 1 << clamp_l2(cfg_l2);
            end
            CFG_INVERSE_MODE: cfg_inv = val & 1;
            CFG_IMAG_SNAP:    cfg_thr = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_phase(input int l2, input int inv, input int thr);
        wait_idle();
        cfg_write(CFG_LOG2_SIZE, l2);
        cfg_write(CFG_INVERSE_MODE, inv);
        cfg_write(CFG_IMAG_SNAP, thr);
    endtask

    // ---------------------------------------------------------------
    // Driver: present queued words, predict on each accepted word
    // ---------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) advance_engine(in_data);
            // advance only when nothing is held or the held word just went in
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (words_pending.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= words_pending.pop_front();
                    send_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random backpressure, compare each bin with the oldest expectation
    // ---------------------------------------------------------------
    int stall_gap = 0;
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (bins_due.size() == 0) begin
                    $error("unexpected bin word: real %0d imag %0d",
                           o_out_data.bin_real, o_out_data.bin_imag);
                    err_cnt++;
                end else begin
                    e = bins_due.pop_front();
                    if (o_out_data.bin_real !== e.bin_real) begin
                        $error("bin_real expected %0d actual %0d", e.bin_real,
                               o_out_data.bin_real);
                        err_cnt++;
                    end
                    if (o_out_data.bin_imag !== e.bin_imag) begin
                        $error("bin_imag expected %0d actual %0d", e.bin_imag,
                               o_out_data.bin_imag);
                        err_cnt++;
                    end
                    if (o_out_data.bin_valid !== e.bin_valid) begin
                        $error("bin_valid expected %0d actual %0d", e.bin_valid,
                               o_out_data.bin_valid);
                        err_cnt++;
                    end
                    if (o_out_data.last_bin !== e.last_bin) begin
                        $error("last_bin expected %0d actual %0d", e.last_bin,
                               o_out_data.last_bin);
                        err_cnt++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_gap = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("FAIL radix2_fft_engine");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int n;
        int i;
        int f;
        int frames;
        int r;
        int thr;
        build_twiddles();
        for (i = 0; i < DEPTH; i++) begin
            re_st[i] = 0;
            im_st[i] = 0;
        end
        ld_cnt  = 0;
        rd_cnt  = 0;
        xf_done = 1'b0;
        cfg_l2  = int'(LOG2_SIZE_RESET);
        cfg_inv = 0;
        cfg_thr = 0;
        g_cnt   = 0;
        g_top   = 0;
        g_n     = 1 << clamp_l2(cfg_l2);
        g_done  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads before any transform return an invalid zero word
        push_read();
        push_read();

        // smallest length: extremes, read wrap, load after transform, early read
        set_phase(1, 0, 0);
        push_load(16'sh7FFF, 16'sh8000);
        push_load(16'sh8000, 16'sh7FFF);
        push_read();
        push_read();
        push_read();
        push_load(16'sh7FFF, -16'sd1);
        push_read();
        push_load(16'sh0000, 16'sh7FFF);
        push_read();
        push_read();

        // inverse with the largest snap threshold on full-scale samples
        set_phase(2, 1, 65535);
        push_load(16'sh7FFF, 16'sh7FFF);
        push_load(16'sh8000, 16'sh8000);
        push_load(16'sh7FFF, 16'sh8000);
        push_load(16'sh8000, 16'sh7FFF);
        repeat (4) push_read();

        // log2_size below range clamps to one
        set_phase(0, 1, 0);
        push_load(16'sh8000, 16'sh0001);
        push_load(16'sh7FFF, 16'sh8000);
        push_read();
        push_read();

        // random phases: mostly complete frames, with noise reads and broken frames
        while (total_words < RANDOM_WORDS) begin
            r = $urandom_range(9);
            case ($urandom_range(3))
                0:       thr = 0;
                1:       thr = $urandom_range(0, 400);
                2:       thr = 65535;
                default: thr = $urandom_range(0, 65535);
            endcase
            burst_mode = ($urandom_range(3) == 0);
            set_phase((r == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5),
                      $urandom_range(1), thr);
            n = g_n;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames && total_words < RANDOM_WORDS; f++) begin
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(9) == 0) push_read();
                    push_load(rand_sample(), rand_sample());
                end
                repeat (n + $urandom_range(0, n)) push_read();
            end
            // leave a frame part-loaded; the next length may be shorter
            if (n > 1 && $urandom_range(4) == 0) begin
                repeat ($urandom_range(1, n - 1)) push_load(rand_sample(), rand_sample());
            end
        end
        burst_mode = 1'b0;

        // out-of-range log2_size clamps to the full length, so the frame stays open
        set_phase(15, $urandom_range(1), $urandom_range(0, 65535));
        push_read();
        repeat (20) push_load(rand_sample(), rand_sample());
        repeat (3) push_read();

        // shrink the length under the open frame: the next load starts the transform
        set_phase(3, 0, 0);
        push_load(rand_sample(), rand_sample());
        repeat (10) push_read();

        wait_idle();
        if (err_cnt == 0) begin
            $display("PASS radix2_fft_engine");
        end else begin
            $display("FAIL radix2_fft_engine");
        end
        $finish;
    end

endmodule

/* radix2_fft_engine.f */
src/r2fft_pkg.sv
src/r2fft_store.sv
src/r2fft_twiddle.sv
src/r2fft_bfly.sv
src/radix2_fft_engine.sv
dv/tb_top.sv
